FILE: design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, step codes and helpers for the environmental sensor
// compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_TEMP      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRES_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRES_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIXED     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM       = 3'd4;

  // arithmetic constants of the compensation scheme
  localparam logic [31:0] K_PRES_OFS   = 32'd64000;
  localparam logic [31:0] K_HUM_OFS    = 32'd76800;
  localparam logic [31:0] K_PRES_SCALE = 32'd3125;
  localparam logic [31:0] K_PRES_FULL  = 32'd1048576;
  localparam logic [31:0] K_HUM_MAX    = 32'd419430400;
  localparam logic [31:0] K_HUM_BIAS   = 32'd2097152;
  localparam logic [31:0] K_HALF_15    = 32'd16384;
  localparam logic [31:0] K_ONE_15     = 32'd32768;
  localparam logic [31:0] K_HALF_14    = 32'd8192;
  // reciprocal of ten scaled by 2^35, exact for any 32-bit dividend
  localparam logic [31:0] K_RECIP10    = 32'hCCCC_CCCD;

  // datapath step codes, in sequence order
  typedef enum logic [5:0] {
    OP_NONE,
    OP_T0, OP_T1, OP_T2, OP_T3, OP_TDIV, OP_TEND,
    OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_PCHK,
    OP_P8, OP_PDIV, OP_PDEND, OP_P10, OP_P11, OP_P12, OP_P13,
    OP_PTEN, OP_PTEND, OP_PHOLD,
    OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_H5, OP_H6, OP_H7, OP_H8, OP_H9
  } esc_op_e;

  // controller to datapath
  typedef struct packed {
    esc_op_e op;
    logic    capture;
    logic    load_out;
  } esc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic pd_zero;
  } esc_sts_t;

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] sh);
    asr32 = 32'($signed(x) >>> sh);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext12(input logic [11:0] v);
    sext12 = {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    sext8 = {{24{v[7]}}, v};
  endfunction

endpackage

FILE: design/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Integer compensation of raw temperature, pressure and humidity counts.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | sink      | in_valid_i/in_stall_o   | raw temperature/pressure/humidity
//   out      | source    | out_valid_o/out_stall_i | tenths, decapascal, percent, held
//   cfg      | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// a beat passes through the single-cycle steps, one pass through the restoring
// divider and the load into the output register (a zero pressure divisor
// skips the division); the next beat can be taken once the result is loaded
// one beat is in work at a time; the input stalls from acceptance until the
// result has moved into the output register
// a stalled output holds its beat while the next input can be taken
// reset clears coefficients, held pressure and all control state
// ----------------------------------------------------------------------------
module env_sensor_compensation_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [19:0]                 raw_temperature_i,
  input  logic [19:0]                 raw_pressure_i,
  input  logic [15:0]                 raw_humidity_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [10:0]          temperature_tenths_o,
  output logic [15:0]                 pressure_decapascal_o,
  output logic [6:0]                  humidity_percent_o,
  output logic                        pressure_held_o
);
  import esc_pkg::*;

  esc_cmd_t cmd;
  esc_sts_t sts;

  // step sequencer
  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // arithmetic and storage
  esc_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .raw_temperature_i     (raw_temperature_i),
    .raw_pressure_i        (raw_pressure_i),
    .raw_humidity_i        (raw_humidity_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .temperature_tenths_o  (temperature_tenths_o),
    .pressure_decapascal_o (pressure_decapascal_o),
    .humidity_percent_o    (humidity_percent_o),
    .pressure_held_o       (pressure_held_o)
  );

endmodule

FILE: design/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  // shift in the next numerator bit and trial subtract
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= num_i;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

FILE: design/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Step sequencer: walks the datapath through the temperature, pressure and
// humidity steps and owns both handshakes.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output esc_pkg::esc_cmd_t cmd_o,
  input  esc_pkg::esc_sts_t sts_i
);
  import esc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} state_e;

  state_e  state_q;
  esc_op_e op_q;
  esc_op_e ret_q;
  logic    out_valid_q;
  logic    accept;
  logic    load_out;

  // input beat taken only when idle, result loaded once the output is free
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer state and step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      ret_q       <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RUN;
            op_q    <= OP_T0;
          end
        end
        S_RUN: begin
          case (op_q)
            OP_PDIV: begin
              state_q <= S_WAIT;
              op_q    <= OP_NONE;
              ret_q   <= OP_PDEND;
            end
            OP_PCHK: begin
              op_q <= sts_i.pd_zero ? OP_PHOLD : OP_P8;
            end
            OP_PTEND, OP_PHOLD: begin
              op_q <= OP_H0;
            end
            OP_H9: begin
              state_q <= S_OUT;
              op_q    <= OP_NONE;
            end
            default: begin
              op_q <= esc_op_e'(op_q + 6'd1);
            end
          endcase
        end
        S_WAIT: begin
          if (!sts_i.div_busy) begin
            state_q <= S_RUN;
            op_q    <= ret_q;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.op       = op_q;
  assign cmd_o.capture  = accept;
  assign cmd_o.load_out = load_out;

  // an accepted beat starts the sequence at the first temperature step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN) && (op_q == OP_T0))
    else $error("sequence did not start after input beat");

  // no datapath step runs while the divider works
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (op_q == OP_NONE))
    else $error("step issued during divider wait");

  // a loaded result is always presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

FILE: design/esc_dp.sv
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: coefficient registers, working registers, one shared 32-bit
// multiplier and the divider.
// ----------------------------------------------------------------------------
module esc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [63:0]                      cfg_data_i,
  input  logic [19:0]                      raw_temperature_i,
  input  logic [19:0]                      raw_pressure_i,
  input  logic [15:0]                      raw_humidity_i,
  input  esc_pkg::esc_cmd_t                cmd_i,
  output esc_pkg::esc_sts_t                sts_o,
  output logic signed [10:0]               temperature_tenths_o,
  output logic [15:0]                      pressure_decapascal_o,
  output logic [6:0]                       humidity_percent_o,
  output logic                             pressure_held_o
);
  import esc_pkg::*;

  // coefficient registers
  logic [47:0] cfg_t_q;
  logic [63:0] cfg_pl_q;
  logic [63:0] cfg_ph_q;
  logic [47:0] cfg_m_q;
  logic [31:0] cfg_h_q;

  // captured raw counts
  logic [19:0] adc_t_q;
  logic [19:0] adc_p_q;
  logic [15:0] adc_h_q;

  // working registers
  logic [31:0] tfine_q, x_q, y_q, z_q, w_q, sq_q, pd_q, pp_q, q10_q;
  logic        pdiv_hi_q;

  // results and output registers
  logic signed [10:0] tres_q;
  logic [15:0]        pres_q;
  logic [6:0]         hres_q;
  logic               held_q;
  logic [15:0]        last_q;
  logic signed [10:0] tout_q;
  logic [15:0]        pout_q;
  logic [6:0]         hout_q;
  logic               hdout_q;

  // unpacked coefficients
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  logic [31:0] ma, mb, m;
  logic [63:0] m64;
  logic [31:0] dd, pnum;
  logic        div_start, div_busy;
  logic [31:0] div_num, div_den, div_q;
  logic signed [33:0] t_val;
  logic signed [10:0] t_sat;
  logic [15:0]        p_sat;
  logic [6:0]         h_sat;

  assign t1 = {16'd0, cfg_t_q[15:0]};
  assign t2 = sext16(cfg_t_q[31:16]);
  assign t3 = sext16(cfg_t_q[47:32]);
  assign p1 = {16'd0, cfg_pl_q[15:0]};
  assign p2 = sext16(cfg_pl_q[31:16]);
  assign p3 = sext16(cfg_pl_q[47:32]);
  assign p4 = sext16(cfg_pl_q[63:48]);
  assign p5 = sext16(cfg_ph_q[15:0]);
  assign p6 = sext16(cfg_ph_q[31:16]);
  assign p7 = sext16(cfg_ph_q[47:32]);
  assign p8 = sext16(cfg_ph_q[63:48]);
  assign p9 = sext16(cfg_m_q[15:0]);
  assign h1 = {24'd0, cfg_m_q[23:16]};
  assign h2 = sext16(cfg_m_q[39:24]);
  assign h3 = {24'd0, cfg_m_q[47:40]};
  assign h4 = sext12(cfg_h_q[11:0]);
  assign h5 = sext12(cfg_h_q[23:12]);
  assign h6 = sext8(cfg_h_q[31:24]);

  assign dd   = {16'd0, adc_t_q[19:4]} - t1;
  assign pnum = (K_PRES_FULL - {12'd0, adc_p_q}) - asr32(y_q, 5'd12);

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_T0:   begin ma = {15'd0, adc_t_q[19:3]} - {15'd0, t1[15:0], 1'b0}; mb = t2; end
      OP_T1:   begin ma = dd; mb = dd; end
      OP_T2:   begin ma = y_q; mb = t3; end
      OP_T3:   begin ma = tfine_q; mb = 32'd5; end
      OP_TDIV: begin ma = x_q[31] ? (32'd0 - x_q) : x_q; mb = K_RECIP10; end
      OP_P1:   begin ma = asr32(x_q, 5'd2); mb = asr32(x_q, 5'd2); end
      OP_P2:   begin ma = asr32(sq_q, 5'd11); mb = p6; end
      OP_P3:   begin ma = x_q; mb = p5; end
      OP_P5:   begin ma = p3; mb = asr32(sq_q, 5'd13); end
      OP_P6:   begin ma = p2; mb = x_q; end
      OP_P7:   begin ma = K_ONE_15 + x_q; mb = p1; end
      OP_P8:   begin ma = pnum; mb = K_PRES_SCALE; end
      OP_P10:  begin ma = pp_q >> 3; mb = pp_q >> 3; end
      OP_P11:  begin ma = p9; mb = z_q; end
      OP_P12:  begin ma = pp_q >> 2; mb = p8; end
      OP_PTEN: begin ma = pp_q; mb = K_RECIP10; end
      OP_H1:   begin ma = h5; mb = w_q; end
      OP_H2:   begin ma = w_q; mb = h6; end
      OP_H3:   begin ma = w_q; mb = h3; end
      OP_H4:   begin ma = y_q; mb = z_q; end
      OP_H5:   begin ma = y_q; mb = h2; end
      OP_H6:   begin ma = x_q; mb = y_q; end
      OP_H7:   begin ma = asr32(w_q, 5'd15); mb = asr32(w_q, 5'd15); end
      OP_H8:   begin ma = z_q; mb = h1; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // shared multiplier, full product for the divide-by-ten steps
  assign m64 = {32'd0, ma} * {32'd0, mb};
  assign m   = m64[31:0];

  // divider runs only the pressure division
  always_comb begin
    div_start = (cmd_i.op == OP_PDIV);
    div_num   = pp_q[31] ? pp_q : {pp_q[30:0], 1'b0};
    div_den   = pd_q;
  end

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_q)
  );

  // result saturation
  assign t_val = x_q[31] ? -$signed({2'b00, q10_q}) : $signed({2'b00, q10_q});
  always_comb begin
    if (t_val < -34'sd400) begin
      t_sat = -11'sd400;
    end else if (t_val > 34'sd850) begin
      t_sat = 11'sd850;
    end else begin
      t_sat = 11'(t_val);
    end
  end
  assign p_sat = (q10_q > 32'd65535) ? 16'hFFFF : q10_q[15:0];
  always_comb begin
    if (w_q[31]) begin
      h_sat = '0;
    end else if (w_q > K_HUM_MAX) begin
      h_sat = 7'd100;
    end else begin
      h_sat = w_q[28:22];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_t_q  <= '0;
      cfg_pl_q <= '0;
      cfg_ph_q <= '0;
      cfg_m_q  <= '0;
      cfg_h_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEMP:      cfg_t_q  <= cfg_data_i[47:0];
        REG_PRES_LOW:  cfg_pl_q <= cfg_data_i;
        REG_PRES_HIGH: cfg_ph_q <= cfg_data_i;
        REG_MIXED:     cfg_m_q  <= cfg_data_i[47:0];
        REG_HUM:       cfg_h_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // held pressure survives between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.op == OP_PTEND) begin
      last_q <= p_sat;
    end
  end

  // working registers, one step per cycle outside the divider wait
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      adc_t_q <= raw_temperature_i;
      adc_p_q <= raw_pressure_i;
      adc_h_q <= raw_humidity_i;
    end
    case (cmd_i.op)
      OP_T0:    x_q     <= asr32(m, 5'd11);
      OP_T1:    y_q     <= asr32(m, 5'd12);
      OP_T2:    tfine_q <= x_q + asr32(m, 5'd14);
      OP_T3:    x_q     <= asr32(m + 32'd128, 5'd8);
      OP_TDIV, OP_PTEN: q10_q <= {3'd0, m64[63:35]};
      OP_TEND:  tres_q  <= t_sat;
      OP_P0:    x_q     <= asr32(tfine_q, 5'd1) - K_PRES_OFS;
      OP_P1:    sq_q    <= m;
      OP_P2:    y_q     <= m;
      OP_P3:    y_q     <= y_q + {m[30:0], 1'b0};
      OP_P4:    y_q     <= asr32(y_q, 5'd2) + {p4[15:0], 16'd0};
      OP_P5:    z_q     <= asr32(m, 5'd3);
      OP_P6:    x_q     <= asr32(z_q + asr32(m, 5'd1), 5'd18);
      OP_P7:    pd_q    <= asr32(m, 5'd15);
      OP_P8:    pp_q    <= m;
      OP_PDIV:  pdiv_hi_q <= pp_q[31];
      OP_PDEND: pp_q    <= pdiv_hi_q ? {div_q[30:0], 1'b0} : div_q;
      OP_P10:   z_q     <= m >> 13;
      OP_P11:   x_q     <= asr32(m, 5'd12);
      OP_P12:   y_q     <= asr32(m, 5'd13);
      OP_P13:   pp_q    <= pp_q + asr32(x_q + y_q + p7, 5'd4);
      OP_PTEND: begin
        pres_q <= p_sat;
        held_q <= 1'b0;
      end
      OP_PHOLD: begin
        pres_q <= last_q;
        held_q <= 1'b1;
      end
      OP_H0:    w_q     <= tfine_q - K_HUM_OFS;
      OP_H1:    x_q     <= asr32({2'b00, adc_h_q, 14'd0} - {h4[11:0], 20'd0} - m
                                 + K_HALF_15, 5'd15);
      OP_H2:    y_q     <= asr32(m, 5'd10);
      OP_H3:    z_q     <= asr32(m, 5'd11) + K_ONE_15;
      OP_H4:    y_q     <= asr32(m, 5'd10) + K_HUM_BIAS;
      OP_H5:    y_q     <= asr32(m + K_HALF_14, 5'd14);
      OP_H6:    w_q     <= m;
      OP_H7:    z_q     <= asr32(m, 5'd7);
      OP_H8:    w_q     <= w_q - asr32(m, 5'd4);
      OP_H9:    hres_q  <= h_sat;
      default: ;
    endcase
    if (cmd_i.load_out) begin
      tout_q  <= tres_q;
      pout_q  <= pres_q;
      hout_q  <= hres_q;
      hdout_q <= held_q;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.pd_zero  = (pd_q == '0);

  assign temperature_tenths_o  = tout_q;
  assign pressure_decapascal_o = pout_q;
  assign humidity_percent_o    = hout_q;
  assign pressure_held_o       = hdout_q;

  // hold path only with a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PHOLD) |-> (pd_q == '0))
    else $error("pressure held with nonzero divisor");

  // division path only with a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_P8) |-> (pd_q != '0))
    else $error("pressure division entered with zero divisor");

  // divider reports busy right after a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the sensor compensation block beat by beat against a predictor of
// the integer temperature, pressure and humidity formulas kept in this bench.
// Directed tests cover reset coefficients, typical and extreme coefficients,
// a zero pressure divisor and unused register indexes. A random part then
// runs many coefficient sets, with gaps and output stalls of random length.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 200;
  localparam logic [CfgIdxW-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic signed [10:0] tenths;
    logic [15:0]        decapascal;
    logic [6:0]         percent;
    logic               held;
  } reading_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [19:0] raw_t;
  logic [19:0] raw_p;
  logic [15:0] raw_h;
  logic out_valid;
  logic out_stall;
  reading_t dut_out;

  // bench copy of the coefficient registers and held pressure
  logic [47:0] temp_cal;
  logic [63:0] pres_cal_lo;
  logic [63:0] pres_cal_hi;
  logic [47:0] mixed_cal;
  logic [31:0] hum_cal;
  logic [15:0] held_pressure;

  reading_t expected_readings[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit quiet;
  int unsigned stall_left;

  env_sensor_compensation_top u_top (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .raw_temperature_i     (raw_t),
    .raw_pressure_i        (raw_p),
    .raw_humidity_i        (raw_h),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .temperature_tenths_o  (dut_out.tenths),
    .pressure_decapascal_o (dut_out.decapascal),
    .humidity_percent_o    (dut_out.percent),
    .pressure_held_o       (dut_out.held)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sgn(input logic [31:0] v, input int bits);
    return sra(v << (32 - bits), 32 - bits);
  endfunction

  // integer compensation of one raw measurement; updates held pressure
  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                          input logic [15:0] rh);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] adc_t, adc_p, adc_h, a, b, d, tfine, p, v, pres;
    int t10, hv;
    reading_t r;
    adc_t = 32'(rt);
    adc_p = 32'(rp);
    adc_h = 32'(rh);
    t1 = 32'(temp_cal[15:0]);
    t2 = sgn(32'(temp_cal[31:16]), 16);
    t3 = sgn(32'(temp_cal[47:32]), 16);
    p1 = 32'(pres_cal_lo[15:0]);
    p2 = sgn(32'(pres_cal_lo[31:16]), 16);
    p3 = sgn(32'(pres_cal_lo[47:32]), 16);
    p4 = sgn(32'(pres_cal_lo[63:48]), 16);
    p5 = sgn(32'(pres_cal_hi[15:0]), 16);
    p6 = sgn(32'(pres_cal_hi[31:16]), 16);
    p7 = sgn(32'(pres_cal_hi[47:32]), 16);
    p8 = sgn(32'(pres_cal_hi[63:48]), 16);
    p9 = sgn(32'(mixed_cal[15:0]), 16);
    h1 = 32'(mixed_cal[23:16]);
    h2 = sgn(32'(mixed_cal[39:24]), 16);
    h3 = 32'(mixed_cal[47:40]);
    h4 = sgn(32'(hum_cal[11:0]), 12);
    h5 = sgn(32'(hum_cal[23:12]), 12);
    h6 = sgn(32'(hum_cal[31:24]), 8);

    // temperature
    a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    tfine = a + b;
    t10 = $signed(sra(tfine * 32'd5 + 32'd128, 8)) / 10;
    if (t10 < -400) t10 = -400;
    if (t10 > 850) t10 = 850;
    r.tenths = 11'(t10);

    // pressure
    a = sra(tfine, 1) - 32'd64000;
    b = sra(sra(a, 2) * sra(a, 2), 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(sra(a, 2) * sra(a, 2), 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a != 32'd0) begin
      p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      p = p + sra(a + b + p7, 4);
      p = p / 32'd10;
      pres = (p > 32'd65535) ? 32'd65535 : p;
      held_pressure = pres[15:0];
      r.held = 1'b0;
    end else begin
      r.held = 1'b1;
    end
    r.decapascal = held_pressure;

    // humidity
    v = tfine - 32'd76800;
    a = sra((adc_h << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
    b = sra(sra(sra(v * h6, 10) * (sra(v * h3, 11) + 32'd32768), 10) + 32'd2097152, 0);
    b = sra(b * h2 + 32'd8192, 14);
    v = a * b;
    v = v - sra(sra(sra(v, 15) * sra(v, 15), 7) * h1, 4);
    hv = $signed(v);
    if (hv < 0) hv = 0;
    if (hv > 419430400) hv = 419430400;
    r.percent = 7'(hv >> 22);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp_v, got_v, cycles);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected beat", 0, 1);
      end else begin
        e = expected_readings.pop_front();
        if (dut_out.tenths !== e.tenths)
          report_mismatch("temperature_tenths", e.tenths, dut_out.tenths);
        if (dut_out.decapascal !== e.decapascal)
          report_mismatch("pressure_decapascal", e.decapascal, dut_out.decapascal);
        if (dut_out.percent !== e.percent)
          report_mismatch("humidity_percent", e.percent, dut_out.percent);
        if (dut_out.held !== e.held)
          report_mismatch("pressure_held", e.held, dut_out.held);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(3, 1);
    if (r < 15) return $urandom_range(10, 4);
    return $urandom_range(80, 20);
  endfunction

  // output stall in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(2) == 0);
      stall_left <= pick_gap();
    end
  end

  // wait for all beats out and the block at rest
  task automatic wait_idle();
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TEMP:      temp_cal = data[47:0];
      REG_PRES_LOW:  pres_cal_lo = data;
      REG_PRES_HIGH: pres_cal_hi = data;
      REG_MIXED:     mixed_cal = data[47:0];
      REG_HUM:       hum_cal = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_coeffs(input logic [63:0] tc, input logic [63:0] pl,
                             input logic [63:0] ph, input logic [63:0] mc,
                             input logic [63:0] hc);
    wait_idle();
    write_reg(REG_TEMP, tc);
    write_reg(REG_PRES_LOW, pl);
    write_reg(REG_PRES_HIGH, ph);
    write_reg(REG_MIXED, mc);
    write_reg(REG_HUM, hc);
  endtask

  // typical factory coefficients, upper unused bits set to check they drop
  task automatic load_typical(input logic [15:0] p1);
    load_coeffs({16'hFFFF, -16'sd1000, 16'sd26435, 16'd27504},
                {16'sd2855, 16'sd3024, -16'sd10685, p1},
                {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
                {16'hA5A5, 8'd0, 16'sd362, 8'd75, 16'sd6000},
                {32'hDEAD_BEEF, 8'sd30, 12'sd50, 12'sd313});
  endtask

  // one input beat, valid held high across back-to-back beats
  task automatic send_raw(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_t = t;
    raw_p = p;
    raw_h = h;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(compensate(t, p, h));
    @(negedge clk);
  endtask

  task automatic send_random();
    send_raw(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  task automatic end_burst();
    in_valid = 1'b0;
  endtask

  task automatic test_reset_coeffs();
    // all-zero coefficients give a zero divisor from the start
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    end_burst();
  endtask

  task automatic test_typical();
    load_typical(16'd36477);
    quiet = 1'b1;
    send_raw(20'd519888, 20'd415148, 16'd27000);
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd0, 20'hFFFFF, 16'hFFFF);
    send_raw(20'hFFFFF, 20'd0, 16'd0);
    send_raw(20'd400000, 20'd300000, 16'd40000);
    quiet = 1'b0;
    send_raw(20'd600000, 20'd500000, 16'd10000);
    end_burst();
  endtask

  task automatic test_held_pressure();
    // last stored pressure repeats while the divisor is zero
    load_typical(16'd36477);
    send_raw(20'd519888, 20'd415148, 16'd27000);
    end_burst();
    load_typical(16'd0);
    send_raw(20'd519888, 20'd100000, 16'd27000);
    send_raw(20'd300000, 20'd900000, 16'd5000);
    end_burst();
  endtask

  task automatic test_extreme_coeffs();
    load_coeffs({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    end_burst();
    load_coeffs(64'h8000_8000_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                64'hFF7F_FFFF_7FFF, 64'h7F7F_F7FF);
    send_raw(20'hFFFFF, 20'd0, 16'hFFFF);
    send_raw(20'd0, 20'hFFFFF, 16'd0);
    end_burst();
    load_coeffs(64'h8000_8000_0000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000,
                64'h0080_8000_8000, 64'h8080_0800);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd0, 20'd0, 16'd0);
    end_burst();
  endtask

  task automatic test_unused_index();
    logic [CfgIdxW-1:0] idx;
    load_typical(16'd36477);
    for (idx = REG_FIRST_UNUSED; idx <= REG_LAST_UNUSED && idx >= REG_FIRST_UNUSED; idx++)
      write_reg(idx, {$urandom, $urandom});
    send_raw(20'd519888, 20'd415148, 16'd27000);
    end_burst();
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned done;
    int unsigned burst;
    int unsigned kind;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        // typical set with random spread
        load_coeffs({16'($urandom_range(16'hFFFF, 16'h0800)), 16'($urandom_range(2000)) - 16'd1000,
                     16'd20000 + 16'($urandom_range(12000)), 16'd24000 + 16'($urandom_range(6000))},
                    {16'($urandom_range(4000)), 16'($urandom_range(6000)),
                     -16'sd9000 - 16'($urandom_range(4000)),
                     ($urandom_range(7) == 0) ? 16'd0 : 16'd30000 + 16'($urandom_range(10000))},
                    {-16'sd12000 - 16'($urandom_range(4000)), 16'd14000 + 16'($urandom_range(3000)),
                     -16'sd10 + 16'($urandom_range(20)), 16'($urandom_range(300))},
                    {16'($urandom), 8'($urandom), 16'd300 + 16'($urandom_range(100)),
                     8'($urandom_range(100)), 16'd5000 + 16'($urandom_range(2000))},
                    {32'($urandom), 8'($urandom_range(255)), 12'($urandom_range(100)),
                     12'd250 + 12'($urandom_range(100))});
      end else if (kind < 8) begin
        load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        load_typical(16'd28000 + 16'($urandom_range(16000)));
      end
      quiet = ($urandom_range(5) == 0);
      burst = $urandom_range(120, 60);
      repeat (burst) begin
        if ($urandom_range(3) == 0) send_random();
        else send_raw(20'd400000 + 20'($urandom_range(250000)),
                      20'd250000 + 20'($urandom_range(300000)), 16'($urandom));
        done++;
      end
      end_burst();
      quiet = 1'b0;
    end
  endtask

  // sequence of tests
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TEMP;
    cfg_data = '0;
    in_valid = 1'b0;
    raw_t = '0;
    raw_p = '0;
    raw_h = '0;
    temp_cal = '0;
    pres_cal_lo = '0;
    pres_cal_hi = '0;
    mixed_cal = '0;
    hum_cal = '0;
    held_pressure = '0;
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_coeffs();
    test_typical();
    test_held_pressure();
    test_extreme_coeffs();
    test_unused_index();
    test_random(1430);

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: env_sensor_compensation_top.f
design/esc_pkg.sv
design/esc_div.sv
design/esc_ctrl.sv
design/esc_dp.sv
design/env_sensor_compensation_top.sv
sim/tb_top.sv
